>>> rtl/pngunf_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
`default_nettype none

package pngunf_pkg;

   localparam int MAX_WIDTH       = 1024;
   localparam int BYTES_PER_PIXEL = 4;
   localparam int ROW_DEPTH       = MAX_WIDTH * BYTES_PER_PIXEL;
   localparam int COL_W           = $clog2(ROW_DEPTH);
   localparam int CH_W            = $clog2(BYTES_PER_PIXEL);
   localparam int WIDTH_W         = 11;
   localparam int HEIGHT_W        = 16;
   localparam int STRIDE_W        = WIDTH_W + CH_W;
   localparam int CSR_ADDR_W      = 8;
   localparam int CSR_DATA_W      = 16;

   // Register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

   // Highest legal filter type code
   localparam logic [7:0] FILTER_MAX = 8'd4;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } row_filt_type;

   typedef struct packed {
      logic            bad_filter;
      logic            image_last;
      logic            row_last;
      logic [CH_W-1:0] channel;
      logic [7:0]      pixel_byte;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/pngunf_predict.sv
// Filter predictor and reconstruction of one sample byte.
`default_nettype none

module pngunf_predict (
   input  pngunf_pkg::row_filt_type filter,
   input  logic [7:0]               sample,
   input  logic [7:0]               left,
   input  logic [7:0]               upper,
   input  logic [7:0]               upper_left,
   output logic [7:0]               recon
);
   import pngunf_pkg::*;

   logic signed [9:0] pa;
   logic signed [9:0] pb;
   logic signed [9:0] pc;
   logic [9:0]        abs_a;
   logic [9:0]        abs_b;
   logic [9:0]        abs_c;
   logic [8:0]        avg_sum;
   logic [7:0]        paeth;
   logic [7:0]        pred;

   // Paeth distances: |b-c|, |a-c|, |a+b-2c|
   always_comb begin
      pa = $signed({2'b00, upper}) - $signed({2'b00, upper_left});
      pb = $signed({2'b00, left}) - $signed({2'b00, upper_left});
      pc = pa + pb;
      abs_a = pa[9] ? 10'(-pa) : 10'(pa);
      abs_b = pb[9] ? 10'(-pb) : 10'(pb);
      abs_c = pc[9] ? 10'(-pc) : 10'(pc);
      if (abs_a <= abs_b && abs_a <= abs_c) begin
         paeth = left;
      end else if (abs_b <= abs_c) begin
         paeth = upper;
      end else begin
         paeth = upper_left;
      end
   end

   // Predictor select and modulo-256 add
   always_comb begin
      avg_sum = {1'b0, left} + {1'b0, upper};
      unique case (filter)
         FILT_NONE:  pred = 8'd0;
         FILT_SUB:   pred = left;
         FILT_UP:    pred = upper;
         FILT_AVG:   pred = avg_sum[8:1];
         FILT_PAETH: pred = paeth;
         default:    pred = 8'd0;
      endcase
      recon = sample + pred;
   end

endmodule

`default_nettype wire

>>> rtl/pngunf_skid.sv
// Two-entry output register with skid stage for the result channel.
`default_nettype none

module pngunf_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  pngunf_pkg::result_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output pngunf_pkg::result_type out_data
);
   import pngunf_pkg::*;

   logic       out_valid_ff;
   logic       out_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type out_data_ff;
   result_type out_data_in;
   result_type skid_data_ff;
   result_type skid_data_in;
   logic       push;
   logic       pop;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid_ff && out_ready;

   // Refill the output register from the skid stage first
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

>>> rtl/png_scanline_unfilter_core.sv
// Top level of the PNG scanline unfilter for 8-bit RGBA images.
//
// Usage: the inflated image stream enters on req_* one byte per request.
// Each row starts with a filter type byte (0..4) followed by width*4
// filtered bytes. Every sample byte yields one reconstructed byte on rsp_*,
// with its channel, row and image end marks. A filter type above 4 yields
// one result with the bad filter flag, and the rest of that image is
// swallowed without results. Filter type bytes give no result.
// Throughput: one request per cycle while req_tready is high, set by the update of the
// left/upper-left registers and one line-buffer read and write per cycle.
// Results: each result is registered in the output register, or in the skid entry while one waits.
// The line buffer (4096 bytes) has its read issued ahead, at the next
// column, so its registered data is ready when the next byte arrives.
// Stalls: the output register plus a skid entry let the block take a request
// while a result waits; req_tready drops only while the skid entry is full.
// Reset: width 1, height 1, awaiting a filter byte; no clearing pass, the
// line buffer is only read where the current image has written it.
// Csr writes (index 0 width, 1 height) restart the image; write them only
// while the block is idle.
`default_nettype none

module png_scanline_unfilter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] stream_byte
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [15:0]                          rsp_tdata,  // [7:0] pixel_byte, [8] image_last
   output logic [2:0]                           rsp_tuser,  // [1:0] channel, [2] bad_filter
   output logic                                 rsp_tlast,  // row_last
   // configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pngunf_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [pngunf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pngunf_pkg::*;

   // Registers
   logic [WIDTH_W-1:0]  width_ff,  width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]    col_ff,    col_in;
   logic [HEIGHT_W-1:0] row_ff,    row_in;
   row_filt_type        filter_ff, filter_in;
   logic                expect_ff, expect_in;
   logic                discard_ff, discard_in;
   logic [7:0]          left_ff [BYTES_PER_PIXEL];
   logic [7:0]          left_in [BYTES_PER_PIXEL];
   logic [7:0]          uleft_ff [BYTES_PER_PIXEL];
   logic [7:0]          uleft_in [BYTES_PER_PIXEL];

   // Line buffer
   logic [7:0]          line_mem [ROW_DEPTH];
   logic [7:0]          rd_data_ff;
   logic                mem_we;

   // Datapath
   logic                req_accept;
   logic                csr_accept;
   logic [WIDTH_W-1:0]  width_eff;
   logic [HEIGHT_W-1:0] height_eff;
   logic [STRIDE_W-1:0] stride;
   logic [CH_W-1:0]     ch;
   logic                last_col;
   logic                last_row;
   logic                past_first_pixel;
   logic [7:0]          pred_a;
   logic [7:0]          pred_b;
   logic [7:0]          pred_c;
   logic [7:0]          recon;
   logic                res_valid;
   logic                res_ready;
   result_type          res;
   result_type          rsp_res;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign req_tready = res_ready;
   assign req_accept = req_tvalid && req_tready;

   // Clamp geometry: zero acts as one, width saturates at the buffer size
   always_comb begin
      if (width_ff == '0) begin
         width_eff = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         width_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
      height_eff = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
      stride     = {width_eff, CH_W'(0)};
   end

   // Position and neighbor bytes for the current sample
   assign ch               = col_ff[CH_W-1:0];
   assign last_col         = ({1'b0, col_ff} + 1'b1) >= stride;
   assign last_row         = ({1'b0, row_ff} + 1'b1) >= {1'b0, height_eff};
   assign past_first_pixel = |col_ff[COL_W-1:CH_W];
   assign pred_a = past_first_pixel ? left_ff[ch] : 8'd0;
   assign pred_b = (row_ff != '0) ? rd_data_ff : 8'd0;
   assign pred_c = (row_ff != '0 && past_first_pixel) ? uleft_ff[ch] : 8'd0;

   pngunf_predict u_predict (
      .filter     (filter_ff),
      .sample     (req_tdata),
      .left       (pred_a),
      .upper      (pred_b),
      .upper_left (pred_c),
      .recon      (recon)
   );

   // Next state and result
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      filter_in  = filter_ff;
      expect_in  = expect_ff;
      discard_in = discard_ff;
      left_in    = left_ff;
      uleft_in   = uleft_ff;
      mem_we     = 1'b0;
      res_valid  = 1'b0;
      res        = '0;
      if (csr_accept && (csr_addr == REG_IMAGE_WIDTH || csr_addr == REG_IMAGE_HEIGHT)) begin
         if (csr_addr == REG_IMAGE_WIDTH) begin
            width_in = csr_wdata[WIDTH_W-1:0];
         end else begin
            height_in = csr_wdata[HEIGHT_W-1:0];
         end
         // restart the image
         col_in     = '0;
         row_in     = '0;
         expect_in  = 1'b1;
         discard_in = 1'b0;
         for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
            left_in[i]  = 8'd0;
            uleft_in[i] = 8'd0;
         end
      end else if (req_accept) begin
         if (expect_ff) begin
            // filter type byte opens a row
            expect_in = 1'b0;
            col_in    = '0;
            for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
               left_in[i]  = 8'd0;
               uleft_in[i] = 8'd0;
            end
            if (!discard_ff) begin
               if (req_tdata > FILTER_MAX) begin
                  discard_in     = 1'b1;
                  res_valid      = 1'b1;
                  res.bad_filter = 1'b1;
               end else begin
                  filter_in = row_filt_type'(req_tdata[2:0]);
               end
            end
         end else begin
            // sample byte
            if (!discard_ff) begin
               mem_we         = 1'b1;
               left_in[ch]    = recon;
               uleft_in[ch]   = pred_b;
               res_valid      = 1'b1;
               res.pixel_byte = recon;
               res.channel    = ch;
               res.row_last   = last_col;
               res.image_last = last_col && last_row;
            end
            if (last_col) begin
               expect_in = 1'b1;
               col_in    = '0;
               if (last_row) begin
                  row_in     = '0;
                  discard_in = 1'b0;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_W'(1);
         height_ff  <= HEIGHT_W'(1);
         col_ff     <= '0;
         row_ff     <= '0;
         filter_ff  <= FILT_NONE;
         expect_ff  <= 1'b1;
         discard_ff <= 1'b0;
         for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
            left_ff[i]  <= 8'd0;
            uleft_ff[i] <= 8'd0;
         end
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         filter_ff  <= filter_in;
         expect_ff  <= expect_in;
         discard_ff <= discard_in;
         left_ff    <= left_in;
         uleft_ff   <= uleft_in;
      end
   end

   // Line buffer: write the current column, read ahead at the next one
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[col_ff] <= recon;
      end
      rd_data_ff <= line_mem[col_in];
   end

   pngunf_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_data   (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_res)
   );

   assign rsp_tdata = {7'd0, rsp_res.image_last, rsp_res.pixel_byte};
   assign rsp_tuser = {rsp_res.bad_filter, rsp_res.channel};
   assign rsp_tlast = rsp_res.row_last;

   // Column never runs past the row
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < stride)
      else $error("column counter beyond row stride");

   // A bad filter byte starts discarding the image
   a_bad_discard: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !csr_accept && expect_ff && !discard_ff && req_tdata > FILTER_MAX)
      |=> discard_ff)
      else $error("bad filter did not start discard");

   // No result is produced while discarding
   a_no_res_discard: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> !res_valid)
      else $error("result produced while discarding");

   // Image end mark only ever comes with a row end mark
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_res.image_last) |-> rsp_res.row_last)
      else $error("image end without row end");

endmodule

`default_nettype wire
